[hdl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define MF_ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// condition that must never be seen outside reset
`define MF_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    `MF_ASSERT_AT(lbl, clk, rstn, !(cond), msg)

`endif

[hdl/mf_pkg.sv]
`timescale 1ns / 1ps

package mf_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_CHANNELS = 4;
    localparam int STORE_ROWS   = 4;

    localparam int PIX_W   = 8;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int CH_W    = $clog2(MAX_CHANNELS);
    localparam int SROW_W  = $clog2(STORE_ROWS);
    localparam int ROW_W   = 17;
    localparam int FW_W    = 11;
    localparam int FH_W    = 16;
    localparam int FC_W    = 3;
    localparam int PEND_W  = $clog2((MAX_WIDTH + 1) * MAX_CHANNELS + 1);

    localparam int STORE_DEPTH = STORE_ROWS * MAX_WIDTH * MAX_CHANNELS;
    localparam int STORE_AW    = SROW_W + COL_W + CH_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [FW_W-1:0] RESET_FRAME_WIDTH   = 11'd512;
    localparam logic [FH_W-1:0] RESET_FRAME_HEIGHT  = 16'd512;
    localparam logic [FC_W-1:0] RESET_CHANNEL_COUNT = 3'd3;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_CHANNEL_COUNT = 2'd2
    } cfg_reg_t;

    // where the newest column sits in its row
    typedef enum logic [1:0] {
        COL_WRAP,
        COL_ONE,
        COL_INNER
    } col_sel_t;

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [8:0] win9_t;

    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } column_t;

    typedef struct packed {
        win9_t win;
        logic  last;
    } q_item_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
        logic              full;
    } q_status_t;

    function automatic win9_t cas(input win9_t p, input int a, input int b);
        win9_t q;
        q = p;
        if (p[a] > p[b]) begin
            q[a] = p[b];
            q[b] = p[a];
        end
        return q;
    endfunction

    // nineteen-exchange median network, split into three register stages
    function automatic win9_t med_layers_a(input win9_t p);
        win9_t q;
        q = p;
        q = cas(q, 1, 2); q = cas(q, 4, 5); q = cas(q, 7, 8);
        q = cas(q, 0, 1); q = cas(q, 3, 4); q = cas(q, 6, 7);
        q = cas(q, 1, 2); q = cas(q, 4, 5); q = cas(q, 7, 8);
        return q;
    endfunction

    function automatic win9_t med_layers_b(input win9_t p);
        win9_t q;
        q = p;
        q = cas(q, 0, 3); q = cas(q, 5, 8); q = cas(q, 4, 7);
        q = cas(q, 3, 6); q = cas(q, 1, 4); q = cas(q, 2, 5);
        q = cas(q, 4, 7);
        return q;
    endfunction

    function automatic win9_t med_layers_c(input win9_t p);
        win9_t q;
        q = p;
        q = cas(q, 4, 2);
        q = cas(q, 6, 4);
        q = cas(q, 4, 2);
        return q;
    endfunction

endpackage

[hdl/mf_ram.sv]
`timescale 1ns / 1ps

module mf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

[hdl/mf_front.sv]
`timescale 1ns / 1ps

module mf_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [mf_pkg::PIX_W-1:0]       s_sample,
    input  logic                           s_drain,
    input  logic                           cfg_valid,
    input  logic [mf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  mf_pkg::q_status_t              q_status,
    output logic                           q_push,
    output mf_pkg::q_item_t                q_item
);
    import mf_pkg::*;

    logic [FW_W-1:0]   w_reg, w_next;
    logic [FH_W-1:0]   h_reg, h_next;
    logic [FC_W-1:0]   c_reg, c_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [PEND_W-1:0] pending_reg, pending_next;

    logic [PEND_W-1:0] lag;
    logic              in_done, space, take, samp_ev, drain_ev, ev, emit, last;
    logic [FC_W-1:0]   ch_inc;
    logic [FW_W-1:0]   col_inc;
    col_sel_t          sel;

    logic              s1_valid_reg;
    logic              s1_emit_reg, s1_last_reg, s1_wide_reg;
    logic              s1_top_ok_reg, s1_mid_ok_reg, s1_bot_ok_reg;
    logic [CH_W-1:0]   s1_ch_reg;
    col_sel_t          s1_sel_reg;
    pix_t              s1_sample_reg;

    logic [STORE_AW-1:0] waddr, raddr_top, raddr_mid;
    logic [SROW_W-1:0]   srow_top, srow_mid;
    pix_t                rd_top, rd_mid;

    column_t win_old_reg [MAX_CHANNELS];
    column_t win_new_reg [MAX_CHANNELS];
    column_t nc, lc, mc, rc, zc;

    assign in_done = row_reg >= ROW_W'(h_reg);
    assign lag     = (PEND_W'(w_reg) + PEND_W'(1)) * PEND_W'(c_reg);
    assign space   = (q_status.count + QCNT_W'(q_push)) < QCNT_W'(QDEPTH);
    assign s_ready = space;
    assign take    = s_valid && space;

    assign samp_ev  = take && !s_drain && !in_done;
    assign drain_ev = take && in_done && (pending_reg != '0);
    assign ev       = samp_ev || drain_ev;
    assign emit     = samp_ev ? (pending_reg >= lag) : drain_ev;
    assign last     = drain_ev && (pending_reg == PEND_W'(1));

    assign ch_inc  = FC_W'(ch_reg) + FC_W'(1);
    assign col_inc = FW_W'(col_reg) + FW_W'(1);

    always_comb begin
        w_next       = w_reg;
        h_next       = h_reg;
        c_next       = c_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        ch_next      = ch_reg;
        pending_next = pending_reg;
        if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH: begin
                    if (cfg_data[FW_W-1:0] == '0) begin
                        w_next = FW_W'(1);
                    end else if (cfg_data[FW_W-1:0] > FW_W'(MAX_WIDTH)) begin
                        w_next = FW_W'(MAX_WIDTH);
                    end else begin
                        w_next = cfg_data[FW_W-1:0];
                    end
                end
                REG_FRAME_HEIGHT: begin
                    h_next = (cfg_data[FH_W-1:0] == '0) ? FH_W'(1) : cfg_data[FH_W-1:0];
                end
                REG_CHANNEL_COUNT: begin
                    if (cfg_data[FC_W-1:0] == '0) begin
                        c_next = FC_W'(1);
                    end else if (cfg_data[FC_W-1:0] > FC_W'(MAX_CHANNELS)) begin
                        c_next = FC_W'(MAX_CHANNELS);
                    end else begin
                        c_next = cfg_data[FC_W-1:0];
                    end
                end
                default: begin
                end
            endcase
            row_next     = '0;
            col_next     = '0;
            ch_next      = '0;
            pending_next = '0;
        end else if (ev) begin
            if (last) begin
                row_next     = '0;
                col_next     = '0;
                ch_next      = '0;
                pending_next = '0;
            end else begin
                if (ch_inc >= c_reg) begin
                    ch_next = '0;
                    if (col_inc >= w_reg) begin
                        col_next = '0;
                        row_next = row_reg + ROW_W'(1);
                    end else begin
                        col_next = col_inc[COL_W-1:0];
                    end
                end else begin
                    ch_next = ch_inc[CH_W-1:0];
                end
                if (drain_ev) begin
                    pending_next = pending_reg - PEND_W'(1);
                end else if (!emit) begin
                    pending_next = pending_reg + PEND_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg        <= RESET_FRAME_WIDTH;
            h_reg        <= RESET_FRAME_HEIGHT;
            c_reg        <= RESET_CHANNEL_COUNT;
            row_reg      <= '0;
            col_reg      <= '0;
            ch_reg       <= '0;
            pending_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            w_reg        <= w_next;
            h_reg        <= h_next;
            c_reg        <= c_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            ch_reg       <= ch_next;
            pending_reg  <= pending_next;
            s1_valid_reg <= ev;
        end
    end

    always_comb begin
        if (col_reg == '0) begin
            sel = COL_WRAP;
        end else if (col_reg == COL_W'(1)) begin
            sel = COL_ONE;
        end else begin
            sel = COL_INNER;
        end
    end

    always_ff @(posedge aclk) begin
        s1_emit_reg   <= emit;
        s1_last_reg   <= last;
        s1_wide_reg   <= w_reg >= FW_W'(2);
        s1_top_ok_reg <= row_reg >= ROW_W'(2);
        s1_mid_ok_reg <= (row_reg >= ROW_W'(1)) && (row_reg <= ROW_W'(h_reg));
        s1_bot_ok_reg <= samp_ev;
        s1_ch_reg     <= ch_reg;
        s1_sel_reg    <= sel;
        s1_sample_reg <= s_sample;
    end

    // rows above the incoming sample, modulo the four stored rows
    assign srow_mid  = row_reg[SROW_W-1:0] - SROW_W'(1);
    assign srow_top  = row_reg[SROW_W-1:0] - SROW_W'(2);
    assign waddr     = {row_reg[SROW_W-1:0], col_reg, ch_reg};
    assign raddr_mid = {srow_mid, col_reg, ch_reg};
    assign raddr_top = {srow_top, col_reg, ch_reg};

    mf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_line_store (
        .aclk    (aclk),
        .we      (samp_ev),
        .waddr   (waddr),
        .wdata   (s_sample),
        .raddr_a (raddr_top),
        .rdata_a (rd_top),
        .raddr_b (raddr_mid),
        .rdata_b (rd_mid)
    );

    assign zc     = '0;
    assign nc.top = s1_top_ok_reg ? rd_top : '0;
    assign nc.mid = s1_mid_ok_reg ? rd_mid : '0;
    assign nc.bot = s1_bot_ok_reg ? s1_sample_reg : '0;

    always_comb begin
        mc = win_new_reg[s1_ch_reg];
        unique case (s1_sel_reg)
            COL_WRAP: begin
                lc = s1_wide_reg ? win_old_reg[s1_ch_reg] : zc;
                rc = zc;
            end
            COL_ONE: begin
                lc = zc;
                rc = nc;
            end
            COL_INNER: begin
                lc = win_old_reg[s1_ch_reg];
                rc = nc;
            end
            default: begin
                lc = zc;
                rc = zc;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            win_old_reg[s1_ch_reg] <= win_new_reg[s1_ch_reg];
            win_new_reg[s1_ch_reg] <= nc;
        end
    end

    assign q_push      = s1_valid_reg && s1_emit_reg;
    assign q_item.win  = {lc.top, lc.mid, lc.bot, mc.top, mc.mid, mc.bot,
                          rc.top, rc.mid, rc.bot};
    assign q_item.last = s1_last_reg;

endmodule

[hdl/mf_queue.sv]
`timescale 1ns / 1ps

module mf_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  mf_pkg::q_item_t   push_item,
    input  logic              pop,
    output mf_pkg::q_item_t   pop_item,
    output mf_pkg::q_status_t status
);
    import mf_pkg::*;

    q_item_t           mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item     = mem_reg[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.empty = count_reg == '0;
    assign status.full  = count_reg == QCNT_W'(QDEPTH);

endmodule

[hdl/mf_back.sv]
`timescale 1ns / 1ps

module mf_back (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mf_pkg::q_status_t        q_status,
    output logic                     q_pop,
    input  mf_pkg::q_item_t          q_item,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [mf_pkg::PIX_W-1:0] m_median,
    output logic                     m_last_in_frame
);
    import mf_pkg::*;

    logic  adv;
    logic  a_valid_reg, b_valid_reg, out_valid_reg;
    win9_t a_win_reg, b_win_reg, c_win;
    logic  a_last_reg, b_last_reg, out_last_reg;
    pix_t  out_median_reg;

    // whole network moves together, held while a result waits
    assign adv   = !out_valid_reg || m_ready;
    assign q_pop = adv && !q_status.empty;
    assign c_win = med_layers_c(b_win_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg   <= q_pop;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_win_reg      <= med_layers_a(q_item.win);
            a_last_reg     <= q_item.last;
            b_win_reg      <= med_layers_b(a_win_reg);
            b_last_reg     <= a_last_reg;
            out_median_reg <= c_win[4];
            out_last_reg   <= b_last_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_median        = out_median_reg;
    assign m_last_in_frame = out_last_reg;

endmodule

[hdl/median_filter_3x3_core.sv]
`timescale 1ns / 1ps
// 3x3 median filter over an interleaved-channel 8-bit pixel stream
// s_ channel: one request per sample in raster order (row, column, channel);
//   s_drain marks a request with no sample that flushes one pending result
// m_ channel: one median per sample, zero padded at the frame edges;
//   m_last_in_frame marks the final median of a frame and restarts the frame
// cfg channel: frame_width, frame_height, channel_count at indices 0..2,
//   always ready; any write restarts the frame; write only while idle
// results lag the input by (frame_width + 1) * channel_count requests, after
//   which every sample request yields one median; once the frame is in,
//   each drain request yields one of the remaining medians
// path: a median passes the front register stage, the queue, network registers a and b, then the output register
// throughput: one request per cycle while s_ready is high, set by the window update
//   and the three-stage median network that accepts one window a cycle unless the receiver stalls
// reset: frame registers return to 512 x 512 x 3, positions to zero; the
//   line store needs no clearing since every read is of an earlier write
// receiver stall: the output holds, the network freezes, the 4-entry queue
//   fills and s_ready drops until space returns
module median_filter_3x3_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [mf_pkg::PIX_W-1:0]       s_sample,
    input  logic                           s_drain,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [mf_pkg::PIX_W-1:0]       m_median,
    output logic                           m_last_in_frame,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mf_pkg::*;

`include "assert_macros.svh"

    // window hand-off between the classifying front and the median back end
    logic      q_push;
    logic      q_pop;
    q_item_t   q_in;
    q_item_t   q_out;
    q_status_t q_status;

    // configuration never back-pressures
    assign cfg_ready = 1'b1;

    // front: position counters, line store, per-channel window
    mf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_sample  (s_sample),
        .s_drain   (s_drain),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_item    (q_in)
    );

    // short queue so each side can stall on its own
    mf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in),
        .pop       (q_pop),
        .pop_item  (q_out),
        .status    (q_status)
    );

    // back: pipelined median network and output register
    mf_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_status        (q_status),
        .q_pop           (q_pop),
        .q_item          (q_out),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_median        (m_median),
        .m_last_in_frame (m_last_in_frame)
    );

    // the front reserves queue space before it takes a request
    `MF_ASSERT_NEVER(a_queue_no_overflow, aclk, aresetn, q_push && q_status.full, "queue overflow")
    `MF_ASSERT_NEVER(a_queue_no_underflow, aclk, aresetn, q_pop && q_status.empty, "queue underflow")
    // input back-pressure only comes from a backlog in the queue
    `MF_ASSERT_AT(a_stall_has_backlog, aclk, aresetn, !s_ready |-> (q_status.count != '0), "stall without backlog")

endmodule

[verif/median_filter_3x3_core_tb.sv]
`timescale 1ns / 1ps

module median_filter_3x3_core_tb;

    import mf_pkg::*;

    // spare register index: a write restarts the frame and changes nothing else
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // settle time after the last median, enough to cover the pipe
    localparam int SETTLE_CYCLES = 12;
    localparam int RUN_LIMIT_NS  = 5_000_000;

    typedef struct packed {
        logic [PIX_W-1:0] sample;
        logic             drain;
    } request_t;

    typedef struct packed {
        logic [PIX_W-1:0] median;
        logic             last_in_frame;
    } median_result_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [PIX_W-1:0]      s_sample  = '0;
    logic                  s_drain   = 1'b0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [PIX_W-1:0]      m_median;
    logic                  m_last_in_frame;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    median_filter_3x3_core u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .s_drain         (s_drain),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_median        (m_median),
        .m_last_in_frame (m_last_in_frame),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // filter state mirrored on the testbench side
    // ------------------------------------------------------------------

    // raw register contents, saturated on use
    logic [FW_W-1:0] frame_w_reg;
    logic [FH_W-1:0] frame_h_reg;
    logic [FC_W-1:0] chans_reg;

    // copy of the line store and the stream positions
    bit [PIX_W-1:0]  line_copy [STORE_DEPTH];
    int unsigned     next_row, next_col, next_ch;
    longint unsigned medians_out;

    request_t        pending_requests [$];
    median_result_t  expected_medians [$];

    int unsigned     requests_queued, requests_taken;
    int unsigned     medians_checked, frames_ended, reg_writes;
    int unsigned     errors;
    int unsigned     send_idle_pct, recv_idle_pct;

    function automatic int unsigned active_width();
        if (frame_w_reg < 1) return 1;
        if (frame_w_reg > MAX_WIDTH) return MAX_WIDTH;
        return frame_w_reg;
    endfunction

    function automatic int unsigned active_height();
        return (frame_h_reg == 0) ? 1 : frame_h_reg;
    endfunction

    function automatic int unsigned active_channels();
        if (chans_reg < 1) return 1;
        if (chans_reg > MAX_CHANNELS) return MAX_CHANNELS;
        return chans_reg;
    endfunction

    // samples in one whole frame
    function automatic longint unsigned frame_len();
        return longint'(active_width()) * active_height() * active_channels();
    endfunction

    // distance in samples between a request and the median it releases
    function automatic longint unsigned lag_len();
        return longint'(active_width() + 1) * active_channels();
    endfunction

    // medians still owed once a whole frame is in
    function automatic longint unsigned flush_len();
        return (frame_len() < lag_len()) ? frame_len() : lag_len();
    endfunction

    function automatic int unsigned store_slot(int unsigned row, int unsigned col,
                                               int unsigned ch);
        return ((row % STORE_ROWS) * MAX_WIDTH + (col % MAX_WIDTH)) * MAX_CHANNELS
               + (ch % MAX_CHANNELS);
    endfunction

    function automatic void restart_frame();
        next_row    = 0;
        next_col    = 0;
        next_ch     = 0;
        medians_out = 0;
    endfunction

    // fifth of nine over the zero-padded neighbourhood of stream position n
    function automatic logic [PIX_W-1:0] median_of(longint unsigned n, int unsigned w,
                                                  int unsigned h, int unsigned c);
        logic [PIX_W-1:0] v [9];
        logic [PIX_W-1:0] t;
        longint unsigned  pix;
        int unsigned      k, r, col;
        int               rr, cc, cnt;
        pix = n / c;
        k   = n % c;
        r   = pix / w;
        col = pix % w;
        cnt = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                rr = int'(r) + dr;
                cc = int'(col) + dc;
                if (rr >= 0 && rr < int'(h) && cc >= 0 && cc < int'(w))
                    v[cnt] = line_copy[store_slot(rr, cc, k)];
                else
                    v[cnt] = '0;
                cnt++;
            end
        end
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 8 - i; j++) begin
                if (v[j] > v[j+1]) begin
                    t      = v[j];
                    v[j]   = v[j+1];
                    v[j+1] = t;
                end
            end
        end
        return v[4];
    endfunction

    // one accepted request: store the sample, work out whether a median is due
    function automatic void advance_filter(logic [PIX_W-1:0] smp, logic drn);
        int unsigned     w, h, c;
        longint unsigned total, received;
        bit              taken, in_done, give;
        median_result_t  res;
        w        = active_width();
        h        = active_height();
        c        = active_channels();
        total    = longint'(w) * h * c;
        in_done  = (next_row >= h);
        taken    = !drn && !in_done;
        if (taken) begin
            line_copy[store_slot(next_row, next_col, next_ch)] = smp;
            next_ch++;
            if (next_ch >= c) begin
                next_ch = 0;
                next_col++;
                if (next_col >= w) begin
                    next_col = 0;
                    next_row++;
                end
            end
        end
        received = (longint'(next_row) * w + next_col) * c + next_ch;
        if (taken)
            give = (received - medians_out) > lag_len();
        else
            give = in_done && (medians_out < total);
        if (give) begin
            res.median = median_of(medians_out, w, h, c);
            medians_out++;
            res.last_in_frame = (medians_out >= total);
            if (res.last_in_frame)
                restart_frame();
            expected_medians.push_back(res);
        end
    endfunction

    // ------------------------------------------------------------------
    // request driver: one request a cycle at most, random gaps
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drive_requests
        request_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                advance_filter(s_sample, s_drain);
                requests_taken++;
            end
            // the slot is free when nothing is held or the held request just went
            if (!s_valid || s_ready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    req = pending_requests.pop_front();
                    s_valid  <= 1'b1;
                    s_sample <= req.sample;
                    s_drain  <= req.drain;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: random back-pressure, compare against the oldest median
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : watch_medians
        median_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_valid && m_ready) begin
                if (expected_medians.size() == 0) begin
                    $error("median %0d given with none expected", m_median);
                    errors++;
                end else begin
                    want = expected_medians.pop_front();
                    medians_checked++;
                    if (m_median !== want.median) begin
                        $error("median: expected %0d, actual %0d", want.median, m_median);
                        errors++;
                    end
                    if (m_last_in_frame !== want.last_in_frame) begin
                        $error("last_in_frame: expected %0d, actual %0d",
                               want.last_in_frame, m_last_in_frame);
                        errors++;
                    end
                    if (want.last_in_frame)
                        frames_ended++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_request(logic [PIX_W-1:0] smp, logic drn);
        request_t req;
        req.sample = smp;
        req.drain  = drn;
        pending_requests.push_back(req);
        requests_queued++;
    endfunction

    // extremes often, otherwise anything
    function automatic logic [PIX_W-1:0] rand_sample();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    // samples of the frame in progress, with the odd stray drain that is ignored
    function automatic int unsigned queue_samples(int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0)
                push_request(rand_sample(), 1'b1);
            push_request(rand_sample(), 1'b0);
        end
        return n;
    endfunction

    // once the frame is in, a sample also flushes (its value is dropped)
    function automatic int unsigned queue_flush(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            push_request(rand_sample(), $urandom_range(9) < 7);
        return n;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:   frame_w_reg = data[FW_W-1:0];
            REG_FRAME_HEIGHT:  frame_h_reg = data[FH_W-1:0];
            REG_CHANNEL_COUNT: chans_reg   = data[FC_W-1:0];
            default:           ;
        endcase
        restart_frame();
        reg_writes++;
    endtask

    // every request taken, every median back, then let the pipe settle
    task automatic wait_idle();
        do @(posedge aclk);
        while (requests_taken != requests_queued || expected_medians.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // small random geometry, now and then out-of-range register values
    task automatic random_phase(output int unsigned n);
        logic [CFG_DATA_W-1:0] wd, hd, cd;
        int unsigned           frames;
        wd = CFG_DATA_W'($urandom);
        wd[FW_W-1:0] = ($urandom_range(19) == 0) ? '0 : FW_W'($urandom_range(1, 12));
        hd = ($urandom_range(19) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 6));
        cd = CFG_DATA_W'($urandom);
        case ($urandom_range(9))
            0:       cd[FC_W-1:0] = '0;
            1:       cd[FC_W-1:0] = FC_W'($urandom_range(5, 7));
            default: cd[FC_W-1:0] = FC_W'($urandom_range(1, 4));
        endcase
        if ($urandom_range(7) == 0)
            write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        write_reg(REG_FRAME_WIDTH, wd);
        write_reg(REG_FRAME_HEIGHT, hd);
        write_reg(REG_CHANNEL_COUNT, cd);
        n = 0;
        if ($urandom_range(4) == 0) begin
            // cut the frame short, the next register write abandons it
            if (frame_len() > 1)
                n = queue_samples($urandom_range(1, 32'(frame_len() - 1)));
        end else begin
            // whole frames back to back, each ends on its marked median
            frames = $urandom_range(1, 3);
            repeat (frames) begin
                n += queue_samples(32'(frame_len()));
                n += queue_flush(32'(flush_len()));
            end
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned sent, n;
        frame_w_reg   = RESET_FRAME_WIDTH;
        frame_h_reg   = RESET_FRAME_HEIGHT;
        chans_reg     = RESET_CHANNEL_COUNT;
        restart_frame();
        send_idle_pct = 15;
        recv_idle_pct = 54;
        sent          = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset geometry: early drains are ignored, samples release nothing yet
        push_request(8'h00, 1'b1);
        push_request(8'h00, 1'b0);
        push_request(8'hFF, 1'b0);
        push_request(8'hFF, 1'b1);
        wait_idle();

        // zero in every register reads as a 1 x 1 x 1 frame; spare index restarts
        write_reg(REG_UNUSED, '1);
        write_reg(REG_FRAME_WIDTH, '0);
        write_reg(REG_FRAME_HEIGHT, '0);
        write_reg(REG_CHANNEL_COUNT, '0);
        push_request(8'hFF, 1'b0);
        push_request(8'h5A, 1'b0);    // frame is in: acts as a flush
        push_request(8'hA5, 1'b1);    // new frame not yet in: ignored
        wait_idle();

        // 3 x 3 single channel of full scale: corners pad to 0, the rest stay high
        write_reg(REG_FRAME_WIDTH, 16'd3);
        write_reg(REG_FRAME_HEIGHT, 16'd3);
        write_reg(REG_CHANNEL_COUNT, 16'd1);
        repeat (9) push_request(8'hFF, 1'b0);
        repeat (4) push_request(8'h00, 1'b1);
        wait_idle();

        while (sent < 370) begin
            random_phase(n);
            sent += n;
        end

        send_idle_pct = 54;
        recv_idle_pct = 15;

        // widest row, saturated from all ones, one row so both pads show
        write_reg(REG_FRAME_WIDTH, '1);
        write_reg(REG_FRAME_HEIGHT, 16'd1);
        write_reg(REG_CHANNEL_COUNT, 16'd1);
        void'(queue_samples(32'(frame_len())));
        void'(queue_flush(32'(flush_len())));
        wait_idle();

        // tallest frame with channels saturated to four, abandoned part way
        write_reg(REG_FRAME_WIDTH, 16'd3);
        write_reg(REG_FRAME_HEIGHT, '1);
        write_reg(REG_CHANNEL_COUNT, '1);
        void'(queue_samples(60));
        wait_idle();

        while (sent < 740) begin
            random_phase(n);
            sent += n;
        end

        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (sent < 1100) begin
            random_phase(n);
            sent += n;
        end

        wait_idle();
        $display("%0d requests over %0d register writes; %0d medians checked, %0d frames ended",
                 requests_taken, reg_writes, medians_checked, frames_ended);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // run limit, far beyond the slowest plausible run
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/mf_pkg.sv
hdl/mf_ram.sv
hdl/mf_front.sv
hdl/mf_queue.sv
hdl/mf_back.sv
hdl/median_filter_3x3_core.sv
verif/median_filter_3x3_core_tb.sv
